@@ design/ismcu_pkg.sv @@
// Shared command codes, widths, constants and helper functions of the integer execute unit.
package ismcu_pkg;

   localparam int unsigned DataWidth = 32;
   localparam int unsigned CrWidth   = 4;
   localparam int unsigned CmdWidth  = 4;

   // Request beat: cmd, a, b, imm, mask packed from bit 0, padded to whole bytes.
   localparam int unsigned ReqBits   = CmdWidth + 4 * DataWidth;
   localparam int unsigned ReqWidth  = ((ReqBits + 7) / 8) * 8;
   // Response beat: result, cond_field, carry, overflow, summary_overflow, padded.
   localparam int unsigned RspBits   = DataWidth + CrWidth + 3;
   localparam int unsigned RspWidth  = ((RspBits + 7) / 8) * 8;

   localparam logic [CmdWidth-1:0] CMD_SLW    = 4'd0;
   localparam logic [CmdWidth-1:0] CMD_SRW    = 4'd1;
   localparam logic [CmdWidth-1:0] CMD_SRAW   = 4'd2;
   localparam logic [CmdWidth-1:0] CMD_SRAWI  = 4'd3;
   localparam logic [CmdWidth-1:0] CMD_RLWINM = 4'd4;
   localparam logic [CmdWidth-1:0] CMD_RLWNM  = 4'd5;
   localparam logic [CmdWidth-1:0] CMD_CNTLZW = 4'd6;
   localparam logic [CmdWidth-1:0] CMD_MULHW  = 4'd7;
   localparam logic [CmdWidth-1:0] CMD_MULHWU = 4'd8;
   localparam logic [CmdWidth-1:0] CMD_MULLI  = 4'd9;
   localparam logic [CmdWidth-1:0] CMD_MULLWO = 4'd10;
   localparam logic [CmdWidth-1:0] CMD_CMP    = 4'd11;
   localparam logic [CmdWidth-1:0] CMD_CMPLW  = 4'd12;
   localparam logic [CmdWidth-1:0] CMD_RECORD = 4'd13;
   localparam logic [CmdWidth-1:0] CMD_NEGO   = 4'd14;
   localparam logic [CmdWidth-1:0] CMD_SUBF   = 4'd15;

   localparam logic [DataWidth-1:0] SIGN32 = 32'h8000_0000;
   localparam logic [DataWidth-1:0] ALL32  = 32'hffff_ffff;

   typedef struct packed {
      logic [CmdWidth-1:0]  cmd;
      logic [DataWidth-1:0] a;
      logic [DataWidth-1:0] b;
      logic [DataWidth-1:0] imm;
      logic [DataWidth-1:0] mask;
   } req_type;

   typedef struct packed {
      logic [DataWidth-1:0] result;
      logic [CrWidth-1:0]   cond_field;
      logic                 carry;
      logic                 overflow;
      logic                 summary_overflow;
   } rsp_type;

   // Leading zeros of one byte, 0 to 8.
   function automatic logic [3:0] clz8(input logic [7:0] v);
      logic [3:0] n;
      logic       found;
      n     = 4'd0;
      found = 1'b0;
      for (int i = 7; i >= 0; i--) begin
         if (v[i]) begin
            found = 1'b1;
         end else if (!found) begin
            n = n + 4'd1;
         end
      end
      return n;
   endfunction

   // Leading zeros of a word, 0 to 32: picks the first nonzero byte.
   function automatic logic [5:0] clz32(input logic [DataWidth-1:0] v);
      logic [5:0] n;
      if (v[31:24] != 8'd0) begin
         n = {2'b00, clz8(v[31:24])};
      end else if (v[23:16] != 8'd0) begin
         n = 6'd8 + {2'b00, clz8(v[23:16])};
      end else if (v[15:8] != 8'd0) begin
         n = 6'd16 + {2'b00, clz8(v[15:8])};
      end else begin
         n = 6'd24 + {2'b00, clz8(v[7:0])};
      end
      return n;
   endfunction

endpackage

@@ design/integer_shift_multiply_compare_unit_core.sv @@
// Integer execute unit: shifts, rotate-and-mask, count leading zeros, multiplies, compares, negate, subtract.
//
//   Channel   Direction   Beat contents (from bit 0)
//   req_      in          cmd[3:0], a[35:4], b[67:36], imm[99:68], mask[131:100]
//   rsp_      out         result[31:0], cond_field[35:32], carry, overflow, summary_overflow
//
// One request beat is taken every cycle unless a stalled response holds a full input
// register. It is held in the input register, computed on its way into the result
// register and offered on rsp_ from there.
// The longest path is the 33x33 multiplier between those two registers.
// Reset clears both valid bits and the carry, overflow and summary overflow flags.
// A stalled response holds the whole pipe; the input register still refills
// in the cycle the response is taken.
module integer_shift_multiply_compare_unit_core
   import ismcu_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   // cmd, a, b, imm, mask, zero padding
   input  logic [ReqWidth-1:0] req_tdata,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // result, cond_field, carry, overflow, summary_overflow, zero padding
   output logic [RspWidth-1:0] rsp_tdata
);

   logic    in_valid_ff, in_valid_in;
   req_type in_ff, in_in;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_ff, out_in;
   logic    carry_ff, carry_in;
   logic    ov_ff, ov_in;
   logic    so_ff, so_in;
   logic    advance;

   logic [4:0]             sh_amt;
   logic [DataWidth-1:0]   low_bits;
   logic [DataWidth-1:0]   sra_res;
   logic                   lost;
   logic [2*DataWidth-1:0] rot_wide;
   logic [DataWidth-1:0]   rot_res;
   logic signed [DataWidth:0]     mul_x, mul_y;
   logic signed [2*DataWidth+1:0] prod;
   logic                   mul_ov;
   logic [DataWidth:0]     cmp_x, cmp_y;
   logic                   cmp_lt, cmp_eq;
   logic [CrWidth-1:0]     cr_val;
   logic [DataWidth-1:0]   res;
   logic [CrWidth-1:0]     crf;

   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_in       = in_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
         in_in.cmd   = req_tdata[3:0];
         in_in.a     = req_tdata[35:4];
         in_in.b     = req_tdata[67:36];
         in_in.imm   = req_tdata[99:68];
         in_in.mask  = req_tdata[131:100];
      end
   end

   // Shared datapath pieces.
   always_comb begin
      sh_amt   = (in_ff.cmd == CMD_SRAWI || in_ff.cmd == CMD_RLWINM) ?
                 in_ff.imm[4:0] : in_ff.b[4:0];
      low_bits = ~(ALL32 << sh_amt);
      sra_res  = DataWidth'($signed(in_ff.a) >>> sh_amt);
      lost     = in_ff.a[31] && ((in_ff.a & low_bits) != '0);
      rot_wide = {in_ff.a, in_ff.a} << sh_amt;
      rot_res  = rot_wide[2*DataWidth-1:DataWidth];

      mul_x  = $signed({(in_ff.cmd != CMD_MULHWU) & in_ff.a[31], in_ff.a});
      if (in_ff.cmd == CMD_MULLI) begin
         mul_y = $signed({in_ff.imm[31], in_ff.imm});
      end else begin
         mul_y = $signed({(in_ff.cmd != CMD_MULHWU) & in_ff.b[31], in_ff.b});
      end
      prod   = mul_x * mul_y;
      mul_ov = !((&prod[63:31]) || (~|prod[63:31]));

      cmp_x  = {(in_ff.cmd != CMD_CMPLW) & in_ff.a[31], in_ff.a};
      if (in_ff.cmd == CMD_RECORD) begin
         cmp_y = '0;
      end else begin
         cmp_y = {(in_ff.cmd != CMD_CMPLW) & in_ff.b[31], in_ff.b};
      end
      cmp_lt = $signed(cmp_x) < $signed(cmp_y);
      cmp_eq = cmp_x == cmp_y;
      cr_val = {cmp_lt, !cmp_lt && !cmp_eq, cmp_eq, so_ff};
   end

   always_comb begin
      res      = '0;
      crf      = '0;
      carry_in = carry_ff;
      ov_in    = ov_ff;
      case (in_ff.cmd)
         CMD_SLW: begin
            res = in_ff.b[5] ? '0 : (in_ff.a << sh_amt);
         end
         CMD_SRW: begin
            res = in_ff.b[5] ? '0 : (in_ff.a >> sh_amt);
         end
         CMD_SRAW: begin
            if (in_ff.b[5]) begin
               carry_in = in_ff.a[31];
               res      = {DataWidth{in_ff.a[31]}};
            end else begin
               carry_in = lost;
               res      = sra_res;
            end
         end
         CMD_SRAWI: begin
            carry_in = lost;
            res      = sra_res;
         end
         CMD_RLWINM, CMD_RLWNM: begin
            res = rot_res & in_ff.mask;
         end
         CMD_CNTLZW: begin
            res = {{(DataWidth-6){1'b0}}, clz32(in_ff.a)};
         end
         CMD_MULHW, CMD_MULHWU: begin
            res = prod[2*DataWidth-1:DataWidth];
         end
         CMD_MULLI: begin
            res = prod[DataWidth-1:0];
         end
         CMD_MULLWO: begin
            ov_in = mul_ov;
            res   = prod[DataWidth-1:0];
         end
         CMD_CMP, CMD_CMPLW: begin
            crf = cr_val;
            res = {{(DataWidth-CrWidth){1'b0}}, cr_val};
         end
         CMD_RECORD: begin
            crf = cr_val;
            res = in_ff.a;
         end
         CMD_NEGO: begin
            ov_in = (in_ff.a == SIGN32);
            res   = '0 - in_ff.a;
         end
         default: begin
            res = in_ff.b - in_ff.a;
         end
      endcase
      so_in = so_ff | ov_in;

      if (!(advance && in_valid_ff)) begin
         carry_in = carry_ff;
         ov_in    = ov_ff;
         so_in    = so_ff;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (advance) begin
         out_valid_in        = in_valid_ff;
         out_in.result       = res;
         out_in.cond_field   = crf;
         out_in.carry        = carry_in;
         out_in.overflow     = ov_in;
         out_in.summary_overflow = so_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         carry_ff     <= 1'b0;
         ov_ff        <= 1'b0;
         so_ff        <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         carry_ff     <= carry_in;
         ov_ff        <= ov_in;
         so_ff        <= so_in;
      end
   end

   always_ff @(posedge clock) begin
      in_ff  <= in_in;
      out_ff <= out_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RspWidth-RspBits){1'b0}}, out_ff.summary_overflow, out_ff.overflow,
                        out_ff.carry, out_ff.cond_field, out_ff.result};

endmodule

@@ design/ismcu_checker.sv @@
// Port-level checker for the integer execute unit, bound to the top level.
module ismcu_checker
   import ismcu_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                rsp_tvalid,
   input logic                rsp_tready,
   input logic [RspWidth-1:0] rsp_tdata
);

   logic seen_so_ff, seen_so_in;

   // Summary overflow is sticky: once a taken beat has shown it, every later beat must.
   assign seen_so_in = seen_so_ff || (rsp_tvalid && rsp_tready && rsp_tdata[38]);

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_so_ff <= 1'b0;
      end else begin
         seen_so_ff <= seen_so_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response beat changed while stalled");

   a_so_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && seen_so_ff |-> rsp_tdata[38])
      else $error("summary overflow dropped after being set");

   a_ov_sets_so: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[37] |-> rsp_tdata[38])
      else $error("overflow shown without summary overflow");

   a_cr_form: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[35:33] != 3'd0)
         |-> $onehot(rsp_tdata[35:33]) && (rsp_tdata[32] == rsp_tdata[38]))
      else $error("malformed condition field");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

endmodule

bind integer_shift_multiply_compare_unit_core ismcu_checker u_checker (.*);

@@ dv/integer_shift_multiply_compare_unit_core_test.sv @@
// Self-checking stream testbench for the integer shift, multiply and compare unit.
`timescale 1ns / 100ps

import ismcu_pkg::*;

// Tracks the carry, overflow and summary overflow flags and the results still owed.
class alu_scoreboard;
   bit          carry_flag;
   bit          overflow_flag;
   bit          summary_flag;
   rsp_type     owed_results[$];
   int unsigned errors;

   function new();
      carry_flag    = 1'b0;
      overflow_flag = 1'b0;
      summary_flag  = 1'b0;
      errors        = 0;
   endfunction

   function logic [CrWidth-1:0] cr_value(input bit lt, input bit gt);
      return {lt, gt, !lt && !gt, summary_flag};
   endfunction

   function void record_overflow(input bit ov);
      overflow_flag = ov;
      if (ov) begin
         summary_flag = 1'b1;
      end
   endfunction

   // Arithmetic right shift by 0 to 31; carry is set when a negative value drops a one.
   function logic [DataWidth-1:0] shift_arith(input logic [DataWidth-1:0] a,
                                              input logic [4:0] n);
      carry_flag = a[31] && ((a & ~(ALL32 << n)) != '0);
      return $signed(a) >>> n;
   endfunction

   function rsp_type execute(input logic [CmdWidth-1:0] cmd, input logic [DataWidth-1:0] a,
                             input logic [DataWidth-1:0] b, input logic [DataWidth-1:0] imm,
                             input logic [DataWidth-1:0] mask);
      rsp_type     r;
      logic [63:0] wide;
      longint      product;
      r       = '0;
      product = longint'($signed(a)) * longint'($signed(b));
      case (cmd)
         CMD_SLW: begin
            r.result = b[5] ? '0 : a << b[4:0];
         end
         CMD_SRW: begin
            r.result = b[5] ? '0 : a >> b[4:0];
         end
         CMD_SRAW: begin
            if (b[5]) begin
               carry_flag = a[31];
               r.result   = {DataWidth{a[31]}};
            end else begin
               r.result = shift_arith(a, b[4:0]);
            end
         end
         CMD_SRAWI: begin
            r.result = shift_arith(a, imm[4:0]);
         end
         CMD_RLWINM, CMD_RLWNM: begin
            wide     = {a, a} << ((cmd == CMD_RLWINM) ? imm[4:0] : b[4:0]);
            r.result = wide[63:32] & mask;
         end
         CMD_CNTLZW: begin
            r.result = DataWidth'(DataWidth);
            // The highest set bit is the last one to overwrite the count.
            for (int i = 0; i < DataWidth; i++) begin
               if (a[i]) begin
                  r.result = DataWidth'(DataWidth - 1 - i);
               end
            end
         end
         CMD_MULHW: begin
            r.result = product[63:32];
         end
         CMD_MULHWU: begin
            wide     = {32'd0, a} * {32'd0, b};
            r.result = wide[63:32];
         end
         CMD_MULLI: begin
            r.result = a * imm;
         end
         CMD_MULLWO: begin
            // The product fits in 32 signed bits only when bits 63 to 31 agree.
            record_overflow(!((&product[63:31]) || !(|product[63:31])));
            r.result = product[31:0];
         end
         CMD_CMP: begin
            r.cond_field = cr_value($signed(a) < $signed(b), $signed(a) > $signed(b));
            r.result     = {28'd0, r.cond_field};
         end
         CMD_CMPLW: begin
            r.cond_field = cr_value(a < b, a > b);
            r.result     = {28'd0, r.cond_field};
         end
         CMD_RECORD: begin
            r.cond_field = cr_value(a[31], !a[31] && (a != '0));
            r.result     = a;
         end
         CMD_NEGO: begin
            record_overflow(a == SIGN32);
            r.result = '0 - a;
         end
         default: begin
            r.result = b - a;
         end
      endcase
      r.carry            = carry_flag;
      r.overflow         = overflow_flag;
      r.summary_overflow = summary_flag;
      return r;
   endfunction

   function void note_request(input logic [CmdWidth-1:0] cmd, input logic [DataWidth-1:0] a,
                              input logic [DataWidth-1:0] b, input logic [DataWidth-1:0] imm,
                              input logic [DataWidth-1:0] mask);
      owed_results.push_back(execute(cmd, a, b, imm, mask));
   endfunction

   function void compare_field(input string name, input logic [DataWidth-1:0] want,
                               input logic [DataWidth-1:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      end
   endfunction

   function void check_response(input rsp_type got);
      rsp_type want;
      if (owed_results.size() == 0) begin
         errors++;
         $display("%0t: unexpected beat, expected none actual %h", $time, got);
         return;
      end
      want = owed_results.pop_front();
      compare_field("result", want.result, got.result);
      compare_field("cond_field", {28'd0, want.cond_field}, {28'd0, got.cond_field});
      compare_field("carry", {31'd0, want.carry}, {31'd0, got.carry});
      compare_field("overflow", {31'd0, want.overflow}, {31'd0, got.overflow});
      compare_field("summary_overflow", {31'd0, want.summary_overflow},
                    {31'd0, got.summary_overflow});
   endfunction
endclass

module integer_shift_multiply_compare_unit_core_test;

   localparam int unsigned IdleLimit  = 2000;
   localparam int unsigned RandomBeats = 1900;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [ReqWidth-1:0] req_tdata  = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RspWidth-1:0] rsp_tdata;

   alu_scoreboard board;
   bit            quiet_spell = 1'b0;
   int unsigned   stall_left  = 0;
   int unsigned   idle_cycles = 0;

   integer_shift_multiply_compare_unit_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mostly back to back, sometimes a short pause, now and then a long one.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (quiet_spell) begin
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 65) begin
         return 0;
      end else if (roll < 95) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [DataWidth-1:0] pick_word();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return ALL32;
         2: return SIGN32;
         3: return ~SIGN32;
         4: return 32'd1;
         5: return $urandom_range(0, 255);
         6: return ~$urandom_range(0, 255);
         default: return $urandom;
      endcase
   endfunction

   task automatic send_request(input logic [CmdWidth-1:0] cmd, input logic [DataWidth-1:0] a,
                               input logic [DataWidth-1:0] b, input logic [DataWidth-1:0] imm,
                               input logic [DataWidth-1:0] mask);
      logic [ReqWidth-1:0] beat;
      int unsigned         gap;
      beat              = '0;
      beat[ReqBits-1:0] = {mask, imm, b, a, cmd};
      req_tdata  <= beat;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      board.note_request(cmd, a, b, imm, mask);
      gap = pick_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Response side: check each accepted beat and apply random back-pressure.
   always @(posedge clock) begin
      rsp_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.result           = rsp_tdata[31:0];
         got.cond_field       = rsp_tdata[35:32];
         got.carry            = rsp_tdata[36];
         got.overflow         = rsp_tdata[37];
         got.summary_overflow = rsp_tdata[38];
         board.check_response(got);
      end
      if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_tready <= 1'b1;
         stall_left <= pick_gap();
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles + 1 >= IdleLimit) begin
            $display("tb: failure");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin
      logic [CmdWidth-1:0]  cmd;
      logic [DataWidth-1:0] mask;
      board = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Compares and record come first, while the summary overflow is still clear.
      send_request(CMD_CMP, SIGN32, ~SIGN32, '0, '0);
      send_request(CMD_CMP, 32'h1234_5678, 32'h1234_5678, '0, '0);
      send_request(CMD_CMPLW, SIGN32, 32'd1, '0, '0);
      send_request(CMD_RECORD, '0, '0, '0, '0);
      send_request(CMD_RECORD, ALL32, '0, '0, '0);
      send_request(CMD_RECORD, 32'd7, '0, '0, '0);
      send_request(CMD_SLW, ALL32, 32'd31, '0, '0);
      send_request(CMD_SLW, ALL32, 32'hffff_ffe0, '0, '0);
      send_request(CMD_SRW, ALL32, 32'd63, '0, '0);
      send_request(CMD_SRAW, 32'h8000_0001, 32'd1, '0, '0);
      send_request(CMD_SRAW, SIGN32, 32'd4, '0, '0);
      send_request(CMD_SRAW, 32'h8000_0000, 32'd40, '0, '0);
      send_request(CMD_SRAW, ~SIGN32, 32'd32, '0, '0);
      send_request(CMD_SRAWI, 32'hffff_fff3, '0, 32'hffff_ffe1, '0);
      send_request(CMD_RLWINM, 32'h1234_5678, '0, 32'd36, 32'hffff_0000);
      send_request(CMD_RLWNM, 32'h8000_0001, 32'hffff_ffff, '0, ALL32);
      send_request(CMD_CNTLZW, '0, '0, '0, '0);
      send_request(CMD_CNTLZW, 32'd1, '0, '0, '0);
      send_request(CMD_MULHW, SIGN32, SIGN32, '0, '0);
      send_request(CMD_MULHWU, ALL32, ALL32, '0, '0);
      send_request(CMD_MULLI, ALL32, '0, SIGN32, '0);
      send_request(CMD_MULLWO, 32'd3, 32'd4, '0, '0);
      send_request(CMD_MULLWO, ~SIGN32, 32'd2, '0, '0);
      send_request(CMD_NEGO, '0, '0, '0, '0);
      send_request(CMD_NEGO, SIGN32, '0, '0, '0);
      send_request(CMD_SUBF, 32'd1, '0, '0, '0);

      for (int i = 0; i < RandomBeats; i++) begin
         if (i % 150 == 0) begin
            quiet_spell = ($urandom_range(0, 3) == 0);
         end
         cmd = CmdWidth'($urandom_range(0, 15));
         if ($urandom_range(0, 1) == 1) begin
            mask = (ALL32 >> $urandom_range(0, 31)) & (ALL32 << $urandom_range(0, 31));
         end else begin
            mask = pick_word();
         end
         send_request(cmd, pick_word(), pick_word(), pick_word(), mask);
      end
      req_tvalid <= 1'b0;

      while (board.owed_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);
      if (board.errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
